FILE: hw/rtl/bpr_pkg.sv
`timescale 1ns / 1ps

package bpr_pkg;

  typedef enum logic [1:0] {
    FMT_PALETTE = 2'd0,
    FMT_MASK16  = 2'd1,
    FMT_RGB24   = 2'd2,
    FMT_RGB32   = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    REG_FORMAT       = 3'd0,
    REG_BITFIELDS    = 3'd1,
    REG_RED_MASK     = 3'd2,
    REG_GREEN_MASK   = 3'd3,
    REG_BLUE_MASK    = 3'd4,
    REG_ALPHA_MASK   = 3'd5,
    REG_PALETTE_SIZE = 3'd6
  } reg_idx_t;

  // channel slots: red, green, blue, alpha
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned REM_W     = 40;

  localparam logic [7:0] CHAN_FULL = 8'hFF;

  typedef struct packed {
    fmt_t             fmt;
    logic             bitfields;
    logic [3:0][31:0] mask;
    logic [8:0]       pal_size;
  } cfg_t;

  // item between front and back
  typedef struct packed {
    logic             use_div;
    logic             ok;
    logic [3:0][7:0]  direct;
    logic [3:0][31:0] val;
  } mid_t;

  typedef struct packed {
    logic [3:0][7:0] chan;
    logic            ok;
  } pix_t;

  function automatic logic [4:0] mask_tz(input logic [31:0] mask);
    logic [4:0] tz;
    tz = '0;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) begin
        tz = 5'(i);
      end
    end
    return tz;
  endfunction

  // divisor 2^bits-1 where bits is the span from lowest to highest mask bit
  function automatic logic [31:0] mask_div(input logic [31:0] mask);
    logic [4:0]  msb;
    logic [5:0]  span;
    logic [32:0] full;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (mask[i]) begin
        msb = 5'(i);
      end
    end
    span = 6'({1'b0, msb} - {1'b0, mask_tz(mask)}) + 6'd1;
    full = (33'd1 << span) - 33'd1;
    if (mask == '0) begin
      return 32'd1;
    end
    return full[31:0];
  endfunction

endpackage

FILE: hw/rtl/bpr_fifo.sv
`timescale 1ns / 1ps

module bpr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && (count < CW'(DEPTH));
  assign do_pop  = pop && (count != '0);
  assign empty   = (count == '0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/bpr_front.sv
`timescale 1ns / 1ps

module bpr_front #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  bpr_pkg::cfg_t      cfg,
  input  logic               take,
  input  logic               mode,
  input  logic [31:0]        pixel_word,
  input  logic [7:0]         entry_index,
  input  logic [23:0]        entry_color,
  output logic               out_valid,
  output bpr_pkg::mid_t      out_entry
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] pal_rdata;
  logic        s_valid;
  logic [31:0] s_word;
  logic        s_idx_ok;
  logic [31:0] w;

  always_ff @(posedge clk) begin
    if (take && mode && ({1'b0, entry_index} < 9'(PALETTE_DEPTH))) begin
      pal_mem[entry_index[AW-1:0]] <= entry_color;
    end
    pal_rdata <= pal_mem[pixel_word[AW-1:0]];
    s_word    <= pixel_word;
    s_idx_ok  <= ({1'b0, pixel_word[7:0]} < cfg.pal_size)
              && ({1'b0, pixel_word[7:0]} < 9'(PALETTE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= take && !mode;
    end
  end

  assign out_valid = s_valid;
  assign w = (cfg.fmt == bpr_pkg::FMT_MASK16) ? {16'h0, s_word[15:0]} : s_word;

  always_comb begin
    out_entry = '0;
    out_entry.ok = 1'b1;
    for (int c = 0; c < 4; c++) begin
      out_entry.val[c] = (w & cfg.mask[c]) >> bpr_pkg::mask_tz(cfg.mask[c]);
    end
    case (cfg.fmt)
      bpr_pkg::FMT_PALETTE: begin
        out_entry.ok = s_idx_ok;
        if (s_idx_ok) begin
          out_entry.direct[bpr_pkg::CH_RED]   = pal_rdata[23:16];
          out_entry.direct[bpr_pkg::CH_GREEN] = pal_rdata[15:8];
          out_entry.direct[bpr_pkg::CH_BLUE]  = pal_rdata[7:0];
          out_entry.direct[bpr_pkg::CH_ALPHA] = bpr_pkg::CHAN_FULL;
        end
      end
      bpr_pkg::FMT_MASK16: begin
        out_entry.use_div = 1'b1;
      end
      bpr_pkg::FMT_RGB24, bpr_pkg::FMT_RGB32: begin
        out_entry.use_div = (cfg.fmt == bpr_pkg::FMT_RGB32) && cfg.bitfields;
        out_entry.direct[bpr_pkg::CH_RED]   = s_word[23:16];
        out_entry.direct[bpr_pkg::CH_GREEN] = s_word[15:8];
        out_entry.direct[bpr_pkg::CH_BLUE]  = s_word[7:0];
        out_entry.direct[bpr_pkg::CH_ALPHA] = bpr_pkg::CHAN_FULL;
      end
      default: begin
        out_entry.ok = 1'b1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/bpr_back.sv
`timescale 1ns / 1ps

module bpr_back (
  input  logic          clk,
  input  logic          rst,
  input  bpr_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  bpr_pkg::mid_t in_entry,
  output logic          out_valid,
  output bpr_pkg::pix_t out_pix,
  output logic [3:0]    busy
);

  localparam int unsigned NSTAGE = bpr_pkg::DIV_BITS + 1;

  typedef struct packed {
    logic                                use_div;
    logic                                ok;
    logic [3:0][7:0]                     direct;
    logic [3:0][bpr_pkg::REM_W-1:0]      rem;
    logic [3:0][bpr_pkg::DIV_BITS-1:0]   q;
  } bk_t;

  bk_t              st  [NSTAGE];
  bk_t              nxt [NSTAGE];
  logic [NSTAGE-1:0] vld;
  logic [3:0][31:0] div;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      div[c] = bpr_pkg::mask_div(cfg.mask[c]);
    end
  end

  // stage 0 forms val*255, then one restoring quotient bit per stage
  always_comb begin
    nxt[0].use_div = in_entry.use_div;
    nxt[0].ok      = in_entry.ok;
    nxt[0].direct  = in_entry.direct;
    nxt[0].q       = '0;
    for (int c = 0; c < 4; c++) begin
      nxt[0].rem[c] = (bpr_pkg::REM_W'(in_entry.val[c]) << 8)
                    - bpr_pkg::REM_W'(in_entry.val[c]);
    end
    for (int k = 1; k < NSTAGE; k++) begin
      nxt[k] = st[k-1];
      for (int c = 0; c < 4; c++) begin
        if (st[k-1].rem[c] >= (bpr_pkg::REM_W'(div[c]) << (NSTAGE-1-k))) begin
          nxt[k].rem[c] = st[k-1].rem[c] - (bpr_pkg::REM_W'(div[c]) << (NSTAGE-1-k));
          nxt[k].q[c][NSTAGE-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGE; k++) begin
      st[k] <= nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  assign out_valid = vld[NSTAGE-1];
  assign busy      = 4'($countones(vld));

  always_comb begin
    out_pix.ok   = st[NSTAGE-1].ok;
    out_pix.chan = st[NSTAGE-1].direct;
    if (st[NSTAGE-1].use_div) begin
      out_pix.chan = st[NSTAGE-1].q;
      if (cfg.mask[bpr_pkg::CH_ALPHA] == '0) begin
        out_pix.chan[bpr_pkg::CH_ALPHA] = bpr_pkg::CHAN_FULL;
      end
    end
  end

endmodule

FILE: hw/rtl/bmp_pixel_to_rgba_converter_unit.sv
`timescale 1ns / 1ps

// Converts raw bitmap pixel words to 8-bit RGBA, one item per clock sustained while full stays low.
// Palette writes (mode 1) give no result; conversions (mode 0) give one. A
// front stage does the palette read and field extraction, a four-entry queue
// decouples it from a nine-stage back pipeline (multiply by 255, then eight
// restoring divide steps, one quotient bit each), and a sixteen-entry result
// queue feeds the output. full rises when the middle queue, counting the item
// in the front stage, is out of room; registers must only be written while the
// block holds no pending item.
module bmp_pixel_to_rgba_converter_unit #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [31:0] pixel_word,
  input  logic [7:0]  entry_index,
  input  logic [23:0] entry_color,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        pixel_ok
);

  localparam int unsigned MCW = $clog2(bpr_pkg::MID_DEPTH+1);
  localparam int unsigned OCW = $clog2(bpr_pkg::OUT_DEPTH+1);

  bpr_pkg::cfg_t cfg;
  logic          take;
  logic          f_valid;
  bpr_pkg::mid_t f_entry;
  bpr_pkg::mid_t m_entry;
  logic          m_empty;
  logic [MCW-1:0] m_count;
  logic          m_pop;
  logic          b_valid;
  bpr_pkg::pix_t b_pix;
  logic [3:0]    b_busy;
  bpr_pkg::pix_t o_pix;
  logic [OCW-1:0] o_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt       <= bpr_pkg::FMT_RGB24;
      cfg.bitfields <= 1'b0;
      cfg.mask[bpr_pkg::CH_RED]   <= 32'h0000_7C00;
      cfg.mask[bpr_pkg::CH_GREEN] <= 32'h0000_03E0;
      cfg.mask[bpr_pkg::CH_BLUE]  <= 32'h0000_001F;
      cfg.mask[bpr_pkg::CH_ALPHA] <= 32'h0;
      cfg.pal_size  <= 9'd256;
    end else if (cfg_wen) begin
      case (bpr_pkg::reg_idx_t'(cfg_index))
        bpr_pkg::REG_FORMAT:       cfg.fmt <= bpr_pkg::fmt_t'(cfg_data[1:0]);
        bpr_pkg::REG_BITFIELDS:    cfg.bitfields <= cfg_data[0];
        bpr_pkg::REG_RED_MASK:     cfg.mask[bpr_pkg::CH_RED] <= cfg_data;
        bpr_pkg::REG_GREEN_MASK:   cfg.mask[bpr_pkg::CH_GREEN] <= cfg_data;
        bpr_pkg::REG_BLUE_MASK:    cfg.mask[bpr_pkg::CH_BLUE] <= cfg_data;
        bpr_pkg::REG_ALPHA_MASK:   cfg.mask[bpr_pkg::CH_ALPHA] <= cfg_data;
        bpr_pkg::REG_PALETTE_SIZE: cfg.pal_size <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // front stage plus middle queue must have room for the item in flight
  assign full = ({1'b0, m_count} + (MCW+1)'(f_valid)) >= (MCW+1)'(bpr_pkg::MID_DEPTH);
  assign take = push && !full;

  bpr_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .mode        (mode),
    .pixel_word  (pixel_word),
    .entry_index (entry_index),
    .entry_color (entry_color),
    .out_valid   (f_valid),
    .out_entry   (f_entry)
  );

  bpr_fifo #(
    .WIDTH($bits(bpr_pkg::mid_t)),
    .DEPTH(bpr_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .wdata (f_entry),
    .pop   (m_pop),
    .rdata (m_entry),
    .empty (m_empty),
    .count (m_count)
  );

  // back pipeline never stalls, so reserve a result slot per item in flight
  assign m_pop = !m_empty
              && (({1'b0, o_count} + (OCW+1)'(b_busy)) < (OCW+1)'(bpr_pkg::OUT_DEPTH));

  bpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (m_pop),
    .in_entry  (m_entry),
    .out_valid (b_valid),
    .out_pix   (b_pix),
    .busy      (b_busy)
  );

  bpr_fifo #(
    .WIDTH($bits(bpr_pkg::pix_t)),
    .DEPTH(bpr_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .wdata (b_pix),
    .pop   (pop),
    .rdata (o_pix),
    .empty (empty),
    .count (o_count)
  );

  assign red      = o_pix.chan[bpr_pkg::CH_RED];
  assign green    = o_pix.chan[bpr_pkg::CH_GREEN];
  assign blue     = o_pix.chan[bpr_pkg::CH_BLUE];
  assign alpha    = o_pix.chan[bpr_pkg::CH_ALPHA];
  assign pixel_ok = o_pix.ok;

`ifndef SYNTH
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (m_count < MCW'(bpr_pkg::MID_DEPTH)))
    else $error("middle queue overflow");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (o_count < OCW'(bpr_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pixel_ok) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0))
    else $error("invalid pixel carries nonzero channels");
`endif

endmodule
